// ===== hdl/bal_pkg.sv =====
package bal_pkg;

	// Element width and fixed port widths
	localparam int DW      = 32;
	localparam int FUNC_W  = 3;
	localparam int POS_W   = 6;
	localparam int COUNT_W = 6;

	// Request operation codes
	typedef enum logic [FUNC_W-1:0] {
		FN_INS_END   = 3'd0,
		FN_INS_START = 3'd1,
		FN_INS_POS   = 3'd2,
		FN_REM_FIRST = 3'd3,
		FN_REM_LAST  = 3'd4,
		FN_DUMP      = 3'd5
	} func_t;

	// Response status codes
	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_FULL  = 2'd1,
		STS_EMPTY = 2'd2,
		STS_POS   = 2'd3
	} status_t;

	// What every cell does in a cycle
	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_SHIFT  = 2'd2,
		CELL_ROTATE = 2'd3
	} cell_op_t;

	// Broadcast from the controller to the cell row
	typedef struct packed {
		cell_op_t              op;
		logic signed [DW-1:0]  ins_value;
	} cell_ctrl_t;

endpackage

// ===== hdl/bounded_array_list.sv =====
// Bounded array list: an ordered list of up to DEPTH signed 32-bit values held in a row
// of cells that shift together. Every insert, remove or unknown operation returns one
// response with is_last set; a dump returns one response per stored element (one
// empty response if the list is empty), walking the list by rotating the used cells
// through cell 0, which leaves the list unchanged once the dump ends. A new request is
// taken only when no dump is running and the response register is free or being
// drained. count_after reports the count in 6 bits.
module bounded_array_list #(
	parameter int DEPTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  logic [bal_pkg::FUNC_W-1:0]          func,
	input  logic [bal_pkg::POS_W-1:0]           position,
	input  logic signed [bal_pkg::DW-1:0]       value,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output logic [1:0]                          status,
	output logic signed [bal_pkg::DW-1:0]       element,
	output logic [bal_pkg::COUNT_W-1:0]         count_after,
	output logic                                is_last
);

	localparam int CW  = $clog2(DEPTH + 1);
	localparam int EXW = CW + bal_pkg::POS_W;
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [CW-1:0] ONE      = CW'(1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_DUMP = 2'b10
	} state_t;

	state_t                        state_q, state_d;
	logic [CW-1:0]                 count_q, count_d;
	logic [CW-1:0]                 idx_q, idx_d;
	logic                          rsp_valid_q;
	logic [1:0]                    status_q;
	logic signed [bal_pkg::DW-1:0] element_q;
	logic [bal_pkg::COUNT_W-1:0]   count_after_q;
	logic                          is_last_q;

	logic                          out_free, req_fire, load_out;
	logic [1:0]                    status_d;
	logic signed [bal_pkg::DW-1:0] element_d;
	logic                          is_last_d;
	bal_pkg::cell_ctrl_t           ctrl;
	logic [CW-1:0]                 ins_pos, last_idx;
	logic [EXW-1:0]                pos_ext, count_ext;

	logic signed [bal_pkg::DW-1:0] cell_q [DEPTH];

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE) && out_free;
	assign req_fire  = req_valid && req_ready;
	assign last_idx  = count_q - ONE;
	assign pos_ext   = EXW'(position);
	assign count_ext = EXW'(count_q);

	// Request decode and dump sequencing
	always_comb begin
		state_d        = state_q;
		count_d        = count_q;
		idx_d          = idx_q;
		load_out       = 1'b0;
		status_d       = bal_pkg::STS_OK;
		element_d      = '0;
		is_last_d      = 1'b1;
		ctrl.op        = bal_pkg::CELL_HOLD;
		ctrl.ins_value = value;
		ins_pos        = count_q;
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					load_out = 1'b1;
					case (func)
						bal_pkg::FN_INS_END, bal_pkg::FN_INS_START, bal_pkg::FN_INS_POS: begin
							if (func == bal_pkg::FN_INS_START) begin
								ins_pos = '0;
							end else if (func == bal_pkg::FN_INS_POS) begin
								ins_pos = pos_ext[CW-1:0];
							end
							if (count_q == FULL_CNT) begin
								status_d = bal_pkg::STS_FULL;
							end else if (func == bal_pkg::FN_INS_POS && pos_ext > count_ext) begin
								status_d = bal_pkg::STS_POS;
							end else begin
								ctrl.op = bal_pkg::CELL_INSERT;
								count_d = count_q + ONE;
							end
						end
						bal_pkg::FN_REM_FIRST: begin
							if (count_q == '0) begin
								status_d = bal_pkg::STS_EMPTY;
							end else begin
								ctrl.op = bal_pkg::CELL_SHIFT;
								count_d = count_q - ONE;
							end
						end
						bal_pkg::FN_REM_LAST: begin
							if (count_q == '0) begin
								status_d = bal_pkg::STS_EMPTY;
							end else begin
								count_d = count_q - ONE;
							end
						end
						bal_pkg::FN_DUMP: begin
							if (count_q == '0) begin
								status_d = bal_pkg::STS_EMPTY;
							end else begin
								element_d = cell_q[0];
								ctrl.op   = bal_pkg::CELL_ROTATE;
								is_last_d = (count_q == ONE);
								if (count_q != ONE) begin
									state_d = ST_DUMP;
									idx_d   = ONE;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_DUMP: begin
				if (out_free) begin
					load_out  = 1'b1;
					element_d = cell_q[0];
					ctrl.op   = bal_pkg::CELL_ROTATE;
					is_last_d = (idx_q == last_idx);
					idx_d     = idx_q + ONE;
					if (idx_q == last_idx) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q      <= status_d;
			element_q     <= element_d;
			count_after_q <= bal_pkg::COUNT_W'(count_d);
			is_last_q     <= is_last_d;
		end
	end

	// Cell row
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [bal_pkg::DW-1:0] left_d, right_d;
		if (i == 0) begin : g_first
			assign left_d = value;
		end else begin : g_mid_l
			assign left_d = cell_q[i-1];
		end
		if (i == DEPTH - 1) begin : g_final
			assign right_d = cell_q[0];
		end else begin : g_mid_r
			assign right_d = cell_q[i+1];
		end
		bal_cell #(.CW(CW), .IDX(i)) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.ins_pos  (ins_pos),
			.last_idx (last_idx),
			.left     (left_d),
			.right    (right_d),
			.head     (cell_q[0]),
			.data_q   (cell_q[i])
		);
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign element     = element_q;
	assign count_after = count_after_q;
	assign is_last     = is_last_q;

endmodule

// ===== hdl/bal_cell.sv =====
module bal_cell #(
	parameter int CW  = 6,
	parameter int IDX = 0
) (
	input  logic                           clk,
	input  bal_pkg::cell_ctrl_t            ctrl,
	input  logic [CW-1:0]                  ins_pos,
	input  logic [CW-1:0]                  last_idx,
	input  logic signed [bal_pkg::DW-1:0]  left,
	input  logic signed [bal_pkg::DW-1:0]  right,
	input  logic signed [bal_pkg::DW-1:0]  head,
	output logic signed [bal_pkg::DW-1:0]  data_q
);

	localparam logic [CW-1:0] MY_IDX = CW'(IDX);

	// Insert: cells above the slot move up, the slot takes the new value.
	// Shift: everything moves down one place.
	// Rotate: stored part moves down, head wraps into the last used cell.
	always_ff @(posedge clk) begin
		case (ctrl.op)
			bal_pkg::CELL_INSERT: begin
				if (MY_IDX == ins_pos) begin
					data_q <= ctrl.ins_value;
				end else if (MY_IDX > ins_pos) begin
					data_q <= left;
				end
			end
			bal_pkg::CELL_SHIFT: begin
				data_q <= right;
			end
			bal_pkg::CELL_ROTATE: begin
				if (MY_IDX == last_idx) begin
					data_q <= head;
				end else if (MY_IDX < last_idx) begin
					data_q <= right;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hdl/bal_checker.sv =====
module bal_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                req_valid,
	input logic                                req_ready,
	input logic                                rsp_valid,
	input logic                                rsp_ready,
	input logic [1:0]                          status,
	input logic signed [bal_pkg::DW-1:0]       element,
	input logic [bal_pkg::COUNT_W-1:0]         count_after,
	input logic                                is_last
);

	// Every accepted request produces a response in the next cycle
	a_req_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("no response after accepted request");

	// A stalled response blocks new requests
	a_stall_block: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready)
		else $error("request taken while response stalled");

	// Failed operations carry no element and are always last
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != bal_pkg::STS_OK |-> element == '0 && is_last)
		else $error("error response with element or not last");

	// Non-last dump responses are always OK
	a_dump_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !is_last |-> status == bal_pkg::STS_OK)
		else $error("non-final response with error status");

	// A stalled response holds its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(element) && $stable(status)
			&& $stable(count_after) && $stable(is_last))
		else $error("stalled response changed");

endmodule

bind bounded_array_list bal_checker u_bal_checker (.*);

// ===== sim/tb_bounded_array_list.sv =====
module tb_bounded_array_list;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIST_DEPTH = 32;
	localparam int CYCLE_LIMIT = 200000;
	localparam int REQ_TOTAL = 155;

	// Codes outside the defined set; the block must treat them as no-ops
	localparam logic [bal_pkg::FUNC_W-1:0] FN_UNDEF_A = 3'd6;
	localparam logic [bal_pkg::FUNC_W-1:0] FN_UNDEF_B = 3'd7;

	typedef struct {
		bal_pkg::status_t                 status;
		logic signed [bal_pkg::DW-1:0]    element;
		logic [bal_pkg::COUNT_W-1:0]      count;
		logic                             is_last;
	} list_rsp_t;

	// Mirror of the list contents plus the responses it still owes
	class list_mirror;
		logic signed [bal_pkg::DW-1:0] slots [LIST_DEPTH];
		int fill = 0;
		int errors = 0;
		list_rsp_t owed [$];

		function void owe(bal_pkg::status_t st, logic signed [bal_pkg::DW-1:0] el,
				logic last);
			list_rsp_t r;
			r.status = st;
			r.element = el;
			r.count = bal_pkg::COUNT_W'(fill);
			r.is_last = last;
			owed.push_back(r);
		endfunction

		function bal_pkg::status_t place(int pos, logic signed [bal_pkg::DW-1:0] v);
			if (fill >= LIST_DEPTH) return bal_pkg::STS_FULL;
			if (pos > fill) return bal_pkg::STS_POS;
			for (int i = fill; i > pos; i--) slots[i] = slots[i-1];
			slots[pos] = v;
			fill++;
			return bal_pkg::STS_OK;
		endfunction

		// Apply one accepted request and queue what it should produce
		function void note_request(logic [bal_pkg::FUNC_W-1:0] f,
				logic [bal_pkg::POS_W-1:0] p, logic signed [bal_pkg::DW-1:0] v);
			bal_pkg::status_t st;
			st = bal_pkg::STS_OK;
			case (f)
				bal_pkg::FN_INS_END:   st = place(fill, v);
				bal_pkg::FN_INS_START: st = place(0, v);
				bal_pkg::FN_INS_POS:   st = place(int'(p), v);
				bal_pkg::FN_REM_FIRST: begin
					if (fill == 0) begin
						st = bal_pkg::STS_EMPTY;
					end else begin
						for (int i = 0; i + 1 < fill; i++) slots[i] = slots[i+1];
						fill--;
					end
				end
				bal_pkg::FN_REM_LAST: begin
					if (fill == 0) st = bal_pkg::STS_EMPTY;
					else fill--;
				end
				bal_pkg::FN_DUMP: begin
					if (fill == 0) begin
						owe(bal_pkg::STS_EMPTY, '0, 1'b1);
					end else begin
						for (int i = 0; i < fill; i++)
							owe(bal_pkg::STS_OK, slots[i], (i + 1 == fill));
					end
					return;
				end
				default: ;
			endcase
			owe(st, '0, 1'b1);
		endfunction

		// Compare one accepted response against the oldest owed one
		function void check_response(logic [1:0] st, logic signed [bal_pkg::DW-1:0] el,
				logic [bal_pkg::COUNT_W-1:0] cnt, logic last);
			list_rsp_t e;
			if (owed.size() == 0) begin
				$error("response with nothing owed: status %0d element %0d count %0d",
					st, el, cnt);
				errors++;
				return;
			end
			e = owed.pop_front();
			if (st !== e.status) begin
				$error("status expected %0d actual %0d", e.status, st);
				errors++;
			end
			if (el !== e.element) begin
				$error("element expected %0d actual %0d", e.element, el);
				errors++;
			end
			if (cnt !== e.count) begin
				$error("count_after expected %0d actual %0d", e.count, cnt);
				errors++;
			end
			if (last !== e.is_last) begin
				$error("is_last expected %0d actual %0d", e.is_last, last);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	logic [bal_pkg::FUNC_W-1:0] func;
	logic [bal_pkg::POS_W-1:0] position;
	logic signed [bal_pkg::DW-1:0] value;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	logic [1:0] status;
	logic signed [bal_pkg::DW-1:0] element;
	logic [bal_pkg::COUNT_W-1:0] count_after;
	logic is_last;

	list_mirror mirror;
	int sent = 0;
	int burst_left = 0;
	int cycles = 0;
	int rx_mode = 0;
	int rx_left = 0;
	int rx_tick = 0;

	bounded_array_list #(.DEPTH(LIST_DEPTH)) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.func        (func),
		.position    (position),
		.value       (value),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.status      (status),
		.element     (element),
		.count_after (count_after),
		.is_last     (is_last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Receiver: picks one of four stall modes and holds it for a random run before picking again
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(16, 80);
		end
		rx_left--;
		rx_tick++;
		case (rx_mode)
			0: rsp_ready <= 1'b1;
			1: rsp_ready <= ($urandom_range(0, 3) != 0);
			2: rsp_ready <= ($urandom_range(0, 3) == 0);
			default: rsp_ready <= ((rx_tick % 5) == 0);
		endcase
	end

	// Handshakes are sampled mid-cycle, where every signal is settled
	always @(negedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) mirror.note_request(func, position, value);
			if (rsp_valid && rsp_ready)
				mirror.check_response(status, element, count_after, is_last);
		end
	end

	function automatic logic signed [bal_pkg::DW-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return '0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	// Mostly legal positions, sometimes anything the field holds
	function automatic logic [bal_pkg::POS_W-1:0] pick_position();
		if ($urandom_range(0, 9) < 8)
			return bal_pkg::POS_W'($urandom_range(0, mirror.fill));
		return bal_pkg::POS_W'($urandom_range(0, 63));
	endfunction

	// Send one request; the sender runs in bursts with idle gaps between them
	task automatic issue(input logic [bal_pkg::FUNC_W-1:0] f,
			input logic [bal_pkg::POS_W-1:0] p, input logic signed [bal_pkg::DW-1:0] v);
		int gap;
		bit took;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		func <= f;
		position <= p;
		value <= v;
		req_valid <= 1'b1;
		do begin
			@(negedge clk);
			took = req_ready;
			@(posedge clk);
		end while (!took);
		sent++;
	endtask

	// Stop sending until every owed response has come back
	task automatic drain_wait();
		req_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (mirror.owed.size() != 0);
	endtask

	task automatic issue_insert();
		case ($urandom_range(0, 2))
			0: issue(bal_pkg::FN_INS_END, bal_pkg::POS_W'($urandom), pick_value());
			1: issue(bal_pkg::FN_INS_START, bal_pkg::POS_W'($urandom), pick_value());
			default: issue(bal_pkg::FN_INS_POS, pick_position(), pick_value());
		endcase
	endtask

	task automatic issue_remove();
		if ($urandom_range(0, 1))
			issue(bal_pkg::FN_REM_FIRST, bal_pkg::POS_W'($urandom), $urandom);
		else issue(bal_pkg::FN_REM_LAST, bal_pkg::POS_W'($urandom), $urandom);
	endtask

	task automatic issue_any();
		int r;
		r = $urandom_range(0, 99);
		if (r < 56) issue_insert();
		else if (r < 84) issue_remove();
		else if (r < 92) issue(bal_pkg::FN_DUMP, bal_pkg::POS_W'($urandom), $urandom);
		else if (r < 96) issue(FN_UNDEF_A, bal_pkg::POS_W'($urandom), $urandom);
		else issue(FN_UNDEF_B, bal_pkg::POS_W'($urandom), $urandom);
	endtask

	// Fill to capacity, push against the full list, then read it all back
	task automatic run_fill();
		while (mirror.fill < LIST_DEPTH) issue_insert();
		repeat ($urandom_range(1, 3)) issue_insert();
		issue(bal_pkg::FN_DUMP, bal_pkg::POS_W'($urandom), $urandom);
	endtask

	// Empty the list, with the odd dump on the way, then underflow it
	task automatic run_drain();
		while (mirror.fill > 0) begin
			if ($urandom_range(0, 7) == 0)
				issue(bal_pkg::FN_DUMP, bal_pkg::POS_W'($urandom), $urandom);
			else issue_remove();
		end
		repeat ($urandom_range(1, 2)) issue_remove();
		issue(bal_pkg::FN_DUMP, bal_pkg::POS_W'($urandom), $urandom);
	endtask

	initial begin
		mirror = new();
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		func <= bal_pkg::FN_INS_END;
		position <= '0;
		value <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-list cases, extremes, bad positions, unknown codes
		issue(bal_pkg::FN_DUMP, 6'd0, 32'sd0);
		issue(bal_pkg::FN_REM_FIRST, 6'd0, 32'sd0);
		issue(bal_pkg::FN_REM_LAST, 6'd0, 32'sd0);
		issue(bal_pkg::FN_INS_POS, 6'd1, 32'sd5);
		issue(bal_pkg::FN_INS_POS, 6'd0, 32'sh7FFFFFFF);
		issue(bal_pkg::FN_INS_END, 6'd0, 32'sh80000000);
		issue(bal_pkg::FN_INS_START, 6'd63, -32'sd1);
		issue(bal_pkg::FN_INS_POS, 6'd2, 32'sd0);
		issue(bal_pkg::FN_INS_POS, 6'd4, 32'sh55555555);
		issue(bal_pkg::FN_INS_POS, 6'd63, 32'sh2AAAAAAA);
		issue(bal_pkg::FN_INS_POS, 6'd33, 32'sd7);
		issue(FN_UNDEF_A, 6'd63, -32'sd1);
		issue(FN_UNDEF_B, 6'd0, 32'sd0);
		issue(bal_pkg::FN_DUMP, 6'd0, 32'sd0);
		issue(bal_pkg::FN_REM_FIRST, 6'd0, 32'sd0);
		issue(bal_pkg::FN_REM_LAST, 6'd0, 32'sd0);
		issue(bal_pkg::FN_DUMP, 6'd0, 32'sd0);
		drain_wait();

		// Random phases, starting from a fill so the full list is reached early
		run_fill();
		while (sent < REQ_TOTAL) begin
			case ($urandom_range(0, 2))
				0: run_fill();
				1: run_drain();
				default: repeat ($urandom_range(10, 25)) issue_any();
			endcase
			if ($urandom_range(0, 2) == 0) drain_wait();
		end

		// Wind down: all owed responses, then a quiet tail for strays
		drain_wait();
		repeat (LIST_DEPTH + 16) @(posedge clk);
		if (mirror.owed.size() != 0) begin
			$error("%0d responses never arrived", mirror.owed.size());
			mirror.errors++;
		end
		if (mirror.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== bounded_array_list.f =====
hdl/bal_pkg.sv
hdl/bal_cell.sv
hdl/bounded_array_list.sv
hdl/bal_checker.sv
sim/tb_bounded_array_list.sv
